// File: hw/rtl/spod_pkg.sv
// Shared types and constants for the sphere pair overlap detector.
// Used by every module of the block; depends on nothing else.
package spod_pkg;

   localparam int MaxSpheresDefault = 32;
   localparam int CoordBitsDefault  = 16;

   localparam int FieldBits    = 16;
   localparam int CoordMaxBits = 24;
   localparam int StoreIdxBits = 8;
   localparam int CmpCountBits = 6;
   localparam int MaskBits     = 32;
   localparam int IndexBits    = 5;

   localparam logic [IndexBits-1:0] FullIndex = '1;

   typedef struct packed {
      logic                        new_frame;
      logic signed [FieldBits-1:0] x_pos;
      logic signed [FieldBits-1:0] y_pos;
      logic signed [FieldBits-1:0] z_pos;
      logic [FieldBits-1:0]        radius;
   } req_type;

   typedef struct packed {
      logic [IndexBits-1:0] sphere_index;
      logic [MaskBits-1:0]  hit_mask;
      logic                 overflow;
   } rsp_type;

   // One classified request on its way from the front end to the compare engine.
   typedef struct packed {
      logic signed [CoordMaxBits-1:0] x;
      logic signed [CoordMaxBits-1:0] y;
      logic signed [CoordMaxBits-1:0] z;
      logic [FieldBits-1:0]           radius;
      logic [StoreIdxBits-1:0]        store_idx;
      logic                           store_en;
      logic [CmpCountBits-1:0]        cmp_count;
      logic [IndexBits-1:0]           sphere_index;
      logic                           overflow;
   } cmd_type;

endpackage

// File: hw/rtl/spod_front.sv
// Front end: accepts requests, keeps the frame's sphere count and classifies each sphere.
// Depends on spod_pkg; feeds spod_queue.
module spod_front #(
   parameter int MAX_SPHERES = spod_pkg::MaxSpheresDefault,
   parameter int COORD_BITS  = spod_pkg::CoordBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spod_pkg::req_type req_data,
   input  logic              q_full,
   output logic              q_push,
   output spod_pkg::cmd_type q_cmd
);
   import spod_pkg::*;

   localparam int CNT_W    = $clog2(MAX_SPHERES + 1);
   localparam int EXT_W    = (CNT_W > CmpCountBits) ? CNT_W : CmpCountBits;
   localparam int SIGN_POS = ((COORD_BITS <= FieldBits) ? COORD_BITS : FieldBits) - 1;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_eff;
   logic [EXT_W-1:0] count_ext;
   logic             full;

   // The low COORD_BITS bits are a two's complement value; a wider setting zero-extends.
   function automatic logic signed [CoordMaxBits-1:0] coord_of(input logic [FieldBits-1:0] raw);
      logic [CoordMaxBits-1:0] raw_ext;
      logic                    sign;
      logic [CoordMaxBits-1:0] v;
      raw_ext = CoordMaxBits'(raw);
      sign    = (COORD_BITS <= FieldBits) ? raw[SIGN_POS] : 1'b0;
      for (int k = 0; k < CoordMaxBits; k++) begin
         v[k] = (k < COORD_BITS) ? raw_ext[k] : sign;
      end
      return $signed(v);
   endfunction

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      count_eff = req_data.new_frame ? '0 : count_ff;
      count_ext = EXT_W'(count_eff);
      full      = count_eff >= CNT_W'(MAX_SPHERES);
      count_in  = full ? count_eff : count_eff + CNT_W'(1);

      q_cmd.x            = coord_of(req_data.x_pos);
      q_cmd.y            = coord_of(req_data.y_pos);
      q_cmd.z            = coord_of(req_data.z_pos);
      q_cmd.radius       = req_data.radius;
      q_cmd.store_idx    = StoreIdxBits'(count_eff);
      q_cmd.store_en     = !full;
      q_cmd.cmp_count    = (count_ext > EXT_W'(MaskBits)) ? CmpCountBits'(MaskBits)
                                                          : CmpCountBits'(count_ext);
      q_cmd.sphere_index = full ? FullIndex : count_ext[IndexBits-1:0];
      q_cmd.overflow     = full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (q_push) begin
         count_ff <= count_in;
      end
   end

endmodule

// File: hw/rtl/spod_queue.sv
// Two-entry queue of classified requests between the front end and the compare engine.
// Depends on spod_pkg.
module spod_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  spod_pkg::cmd_type push_cmd,
   input  logic              pop,
   output spod_pkg::cmd_type head_cmd,
   output logic              full,
   output logic              empty
);
   import spod_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;

   assign full     = fill_ff == 2'd2;
   assign empty    = fill_ff == 2'd0;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hw/rtl/spod_back.sv
// Compare engine: holds the sphere store and tests one stored sphere per cycle
// through a read, difference, square and compare pipeline. Depends on spod_pkg.
module spod_back #(
   parameter int MAX_SPHERES = spod_pkg::MaxSpheresDefault,
   parameter int COORD_BITS  = spod_pkg::CoordBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  spod_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spod_pkg::rsp_type rsp_data
);
   import spod_pkg::*;

   localparam int IDX_W  = $clog2(MAX_SPHERES);
   localparam int D_W    = COORD_BITS + 1;
   localparam int SQ_W   = 2 * D_W;
   localparam int RS_W   = FieldBits + 1;
   localparam int RS2_W  = 2 * RS_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int CMP_W  = (DIST_W > RS2_W) ? DIST_W : RS2_W;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
      logic [FieldBits-1:0]         radius;
   } entry_type;

   typedef enum logic [1:0] {StIdle, StRun, StDone} state_type;

   entry_type store_mem [MAX_SPHERES];
   entry_type mem_q_ff;
   entry_type cur_entry;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [CmpCountBits-1:0] issue_ff, issue_in;
   logic                    issue_now, out_free, hit;
   logic                    va_ff, va_in, vd_ff, vd_in, vs_ff, vs_in;
   logic [IndexBits-1:0]    ia_ff, ia_in, id_ff, id_in, is_ff, is_in;
   logic [D_W-1:0]          dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [RS_W-1:0]         rsum_ff, rsum_in;
   logic [SQ_W-1:0]         sqx_ff, sqx_in, sqy_ff, sqy_in, sqz_ff, sqz_in;
   logic [RS2_W-1:0]        rs2_ff, rs2_in;
   logic [CMP_W-1:0]        dist_sq;
   logic [MaskBits-1:0]     mask_ff, mask_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   function automatic logic [D_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] d;
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      return d[COORD_BITS] ? $unsigned(-d) : $unsigned(d);
   endfunction

   always_comb begin
      cur_entry.x      = cmd_ff.x[COORD_BITS-1:0];
      cur_entry.y      = cmd_ff.y[COORD_BITS-1:0];
      cur_entry.z      = cmd_ff.z[COORD_BITS-1:0];
      cur_entry.radius = cmd_ff.radius;
   end

   assign issue_now = (state_ff == StRun) && (issue_ff < cmd_ff.cmp_count);
   assign rd_addr   = IDX_W'(issue_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mem_we    = (state_ff == StDone) && out_free && cmd_ff.store_en;
   assign q_pop     = (state_ff == StIdle) && !q_empty;

   // The store sits behind one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[IDX_W'(cmd_ff.store_idx)] <= cur_entry;
      end
      mem_q_ff <= store_mem[rd_addr];
   end

   always_comb begin
      va_in = issue_now;
      ia_in = issue_ff[IndexBits-1:0];

      vd_in   = va_ff;
      id_in   = ia_ff;
      dx_in   = abs_diff(mem_q_ff.x, cur_entry.x);
      dy_in   = abs_diff(mem_q_ff.y, cur_entry.y);
      dz_in   = abs_diff(mem_q_ff.z, cur_entry.z);
      rsum_in = RS_W'(mem_q_ff.radius) + RS_W'(cur_entry.radius);

      vs_in  = vd_ff;
      is_in  = id_ff;
      sqx_in = dx_ff * dx_ff;
      sqy_in = dy_ff * dy_ff;
      sqz_in = dz_ff * dz_ff;
      rs2_in = rsum_ff * rsum_ff;

      dist_sq = CMP_W'(sqx_ff) + CMP_W'(sqy_ff) + CMP_W'(sqz_ff);
      hit     = dist_sq <= CMP_W'(rs2_ff);

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      issue_in     = issue_now ? issue_ff + CmpCountBits'(1) : issue_ff;
      mask_in      = (vs_ff && hit) ? (mask_ff | (MaskBits'(1) << is_ff)) : mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         StIdle: begin
            if (!q_empty) begin
               cmd_in   = q_head;
               issue_in = '0;
               mask_in  = '0;
               state_in = StRun;
            end
         end
         StRun: begin
            // Done once every read is issued and the pipeline has drained.
            if (!issue_now && !va_ff && !vd_ff && !vs_ff) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.sphere_index  = cmd_ff.sphere_index;
               rsp_data_in.hit_mask      = mask_ff;
               rsp_data_in.overflow      = cmd_ff.overflow;
               state_in                  = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         va_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         vs_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         va_ff        <= va_in;
         vd_ff        <= vd_in;
         vs_ff        <= vs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      issue_ff    <= issue_in;
      mask_ff     <= mask_in;
      ia_ff       <= ia_in;
      id_ff       <= id_in;
      is_ff       <= is_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      rsum_ff     <= rsum_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      sqz_ff      <= sqz_in;
      rs2_ff      <= rs2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/sphere_pair_overlap_detector.sv
// Sphere pair overlap detector. Each request carries one sphere of the current frame; the
// response gives its index in the frame and a mask of the earlier spheres that it touches or
// overlaps, and flags overflow when the frame store is already full. For each sphere the
// compare engine reads min(n, 32) stored spheres, n being the spheres already stored in
// the frame, one per cycle from its single read port, and passes each through a
// three-stage difference, square and compare pipeline. A
// two-entry queue lets the front end keep taking requests while the engine works, and a
// response register lets the engine start the next sphere while a response waits.
module sphere_pair_overlap_detector #(
   parameter int MAX_SPHERES = spod_pkg::MaxSpheresDefault,
   parameter int COORD_BITS  = spod_pkg::CoordBitsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spod_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spod_pkg::rsp_type rsp_data
);
   import spod_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   cmd_type push_cmd;
   cmd_type head_cmd;

   spod_front #(
      .MAX_SPHERES (MAX_SPHERES),
      .COORD_BITS  (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   spod_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   spod_back #(
      .MAX_SPHERES (MAX_SPHERES),
      .COORD_BITS  (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // A sphere that found the store full always reports the last index.
   a_overflow_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.sphere_index == FullIndex)
      else $error("overflow response without the full index");

   // A stored sphere can only be matched against spheres that came before it.
   a_mask_below_index : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.overflow |->
         (MAX_SPHERES > MaskBits) || ((rsp_data.hit_mask >> rsp_data.sphere_index) == '0))
      else $error("hit mask reaches at or above the sphere index");

   // The engine only takes work from a queue that holds some.
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");
`endif

endmodule

// File: test/tb_top.sv
// Testbench for the sphere pair overlap detector: a directed table, then random frames of
// spheres, each response checked against its table value or a frame store predictor.
// Depends on spod_pkg and the sphere_pair_overlap_detector RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import spod_pkg::*;

   localparam int MaxSpheres  = MaxSpheresDefault;
   localparam int ItemTotal   = 1700;
   localparam int CycleLimit  = 1_000_000;
   localparam int DrainCycles = 64;

   typedef struct {
      req_type sphere;
      int      reps;
      bit      known;
      rsp_type want;
   } drill_row;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type frame_spheres [MaxSpheres];
   int      frame_fill = 0;
   rsp_type awaited_rsp [$];
   int      errors = 0;
   int      cycles = 0;
   int      requests_sent = 0;
   int      sender_idle_pct = 38;
   int      taker_idle_pct = 66;

   sphere_pair_overlap_detector u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Compares a sphere with everything held in the current frame, then keeps it if there
   // is room. Distances are formed exactly in 64 bits.
   function automatic rsp_type classify_sphere(input req_type s);
      rsp_type r;
      longint  dx, dy, dz, rsum;
      int      i;
      if (s.new_frame) frame_fill = 0;
      r.hit_mask = '0;
      for (i = 0; i < frame_fill; i++) begin
         dx   = longint'(frame_spheres[i].x_pos) - longint'(s.x_pos);
         dy   = longint'(frame_spheres[i].y_pos) - longint'(s.y_pos);
         dz   = longint'(frame_spheres[i].z_pos) - longint'(s.z_pos);
         rsum = longint'(frame_spheres[i].radius) + longint'(s.radius);
         if (dx * dx + dy * dy + dz * dz <= rsum * rsum) r.hit_mask[i] = 1'b1;
      end
      if (frame_fill >= MaxSpheres) begin
         r.sphere_index = FullIndex;
         r.overflow     = 1'b1;
      end else begin
         r.sphere_index              = frame_fill[IndexBits-1:0];
         r.overflow                  = 1'b0;
         frame_spheres[frame_fill] = s;
         frame_fill++;
      end
      return r;
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows
   // the acceptance of the request.
   task automatic send_sphere(input req_type s, input bit known, input rsp_type want);
      rsp_type predicted;
      if (requests_sent == 600) begin
         sender_idle_pct = 66;
         taker_idle_pct  = 38;
      end else if (requests_sent == 1200) begin
         sender_idle_pct = 0;
         taker_idle_pct  = 0;
      end
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      predicted = classify_sphere(s);
      awaited_rsp.push_back(known ? want : predicted);
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= taker_idle_pct);
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            $error("response with no request outstanding, sphere_index %0d",
                   rsp_data.sphere_index);
            errors++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.sphere_index !== want.sphere_index) begin
               $error("sphere_index: expected %0d, got %0d",
                      want.sphere_index, rsp_data.sphere_index);
               errors++;
            end
            if (rsp_data.hit_mask !== want.hit_mask) begin
               $error("hit_mask: expected %h, got %h", want.hit_mask, rsp_data.hit_mask);
               errors++;
            end
            if (rsp_data.overflow !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("sphere_pair_overlap_detector verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      drill_row drills [];
      req_type  s;
      int       k, pick, frame_len, spread, cx, cy, cz;
      bit       clustered;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      drills = '{
         // First sphere after reset, then an exact touch and a near miss.
         '{'{1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'd3}, 1, 1'b1, '{5'd0, 32'h0, 1'b0}},
         '{'{1'b0, 16'sh0003, 16'sh0004, 16'sh0000, 16'd2}, 1, 1'b1, '{5'd1, 32'h1, 1'b0}},
         '{'{1'b0, 16'sh0003, 16'sh0004, 16'sh0001, 16'd2}, 1, 1'b1, '{5'd2, 32'h2, 1'b0}},
         '{'{1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'd0}, 1, 1'b1, '{5'd0, 32'h0, 1'b0}},
         '{'{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'd0}, 1, 1'b1, '{5'd1, 32'h1, 1'b0}},
         '{'{1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF}, 1, 1'b0, '0},
         '{'{1'b0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hFFFF}, 1, 1'b0, '0},
         '{'{1'b0, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'hFFFF}, 1, 1'b0, '0},
         '{'{1'b0, 16'sh0001, 16'sh7FFF, 16'sh8000, 16'h0001}, 1, 1'b0, '0},
         '{'{1'b1, 16'sh5555, 16'shAAAA, 16'sh5555, 16'hAAAA}, 1, 1'b1, '{5'd0, 32'h0, 1'b0}},
         '{'{1'b0, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'h5555}, 1, 1'b0, '0},
         // Fill one frame to capacity, then push two more spheres into it.
         '{'{1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'd100}, 1, 1'b1, '{5'd0, 32'h0, 1'b0}},
         '{'{1'b0, 16'sh0001, 16'sh0001, 16'sh0001, 16'd100}, 31, 1'b0, '0},
         '{'{1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'd0}, 1, 1'b1,
           '{FullIndex, 32'hFFFF_FFFF, 1'b1}},
         '{'{1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0}, 1, 1'b1, '{FullIndex, 32'h0, 1'b1}},
         '{'{1'b1, 16'sh0005, 16'sh0005, 16'sh0005, 16'd7}, 1, 1'b1, '{5'd0, 32'h0, 1'b0}}
      };
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (drills[row]) begin
         for (k = 0; k < drills[row].reps; k++) begin
            send_sphere(drills[row].sphere, drills[row].known, drills[row].want);
         end
      end

      // Random frames: mostly clustered spheres so that overlaps are common, some scattered
      // ones, the odd frame long enough to overflow and the odd stray frame start.
      while (requests_sent < ItemTotal) begin
         pick      = $urandom_range(99);
         frame_len = (pick < 60) ? $urandom_range(1, 10) :
                     (pick < 85) ? $urandom_range(11, 31) : $urandom_range(32, 36);
         clustered = ($urandom_range(4) != 0);
         spread    = 1 << $urandom_range(2, 12);
         cx        = $urandom;
         cy        = $urandom;
         cz        = $urandom;
         for (k = 0; k < frame_len; k++) begin
            s.new_frame = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(59) == 0);
            if (clustered) begin
               s.x_pos  = 16'(cx + int'($urandom_range(2 * spread)) - spread);
               s.y_pos  = 16'(cy + int'($urandom_range(2 * spread)) - spread);
               s.z_pos  = 16'(cz + int'($urandom_range(2 * spread)) - spread);
               s.radius = ($urandom_range(9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(spread));
            end else begin
               s.x_pos  = 16'($urandom);
               s.y_pos  = 16'($urandom);
               s.z_pos  = 16'($urandom);
               s.radius = 16'($urandom);
            end
            send_sphere(s, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("sphere_pair_overlap_detector verification clean");
      end else begin
         $display("sphere_pair_overlap_detector verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/spod_pkg.sv
hw/rtl/spod_front.sv
hw/rtl/spod_queue.sv
hw/rtl/spod_back.sv
hw/rtl/sphere_pair_overlap_detector.sv
test/tb_top.sv
